[sv/iqe_pkg.sv]
// Package for the indexed queue engine: sizes, operation and status codes,
// sequencer states and the free-slot search function.
// No dependencies.
package iqe_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_OFFER  = 3'd0,
    KIND_POLL   = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_GET    = 3'd3,
    KIND_SET    = 3'd4,
    KIND_DELETE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK,
    S_ACCESS,
    S_FINISH,
    S_EMIT
  } state_e;

  // Lowest-numbered set bit of the free map.
  function automatic logic [ADDR_W-1:0] lowest_free(input logic [DEPTH-1:0] map);
    logic [ADDR_W-1:0] r;
    r = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (map[i]) r = ADDR_W'(i);
    end
    return r;
  endfunction

endpackage

[sv/indexed_queue_engine.sv]
// Indexed queue engine top level: sequencer, head/tail/count/free-map registers
// and three slot RAMs (data, next link, previous link). Uses iqe_pkg, iqe_ram.
//
// The queue holds up to 64 words in linked slots. One operation is in flight at
// a time. Offer, unused kinds and any miss go from dispatch straight to emit.
// Get, set and delete first walk k link hops, where k is min(position,
// count - 1 - position), at most 31; poll and peek start at the head. The link
// walk runs one hop per cycle through the registered read port
// of a link RAM. Each operation writes its RAMs before the next one can read,
// so no forwarding is needed. The result sits in an output register; it is
// overwritten only after it has been transferred.
module indexed_queue_engine import iqe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [1:0]        status_o,
  output logic [DATA_W-1:0] data_out_o,
  output logic [CNT_W-1:0]  count_o
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DEPTH-1:0]  free_q, free_d;
  logic              out_valid_q, out_valid_d;

  kind_e             kind_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] value_q;
  logic              dir_head_q, dir_head_d;
  logic [ADDR_W-1:0] steps_q, steps_d;
  logic [ADDR_W-1:0] target_q, target_d;
  logic              res_hit_q, res_hit_d;
  status_e           res_status_q, res_status_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              out_hit_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CNT_W-1:0]  out_count_q;

  logic              accept, out_load;
  logic [ADDR_W-1:0] rd_addr;
  logic              slot_we, next_we, prev_we;
  logic [ADDR_W-1:0] slot_waddr, next_waddr, prev_waddr;
  logic [DATA_W-1:0] slot_wdata, slot_rd;
  logic [ADDR_W-1:0] next_wdata, prev_wdata, next_rd, prev_rd, link_rd;
  logic [ADDR_W-1:0] free_slot;
  logic [CNT_W-1:0]  tail_steps;
  logic              near_head;
  logic [ADDR_W-1:0] walk_steps;

  assign accept     = in_valid_i && in_ready_o;
  assign free_slot  = lowest_free(free_q);
  assign link_rd    = dir_head_q ? next_rd : prev_rd;
  assign tail_steps = count_q - CNT_W'(1) - CNT_W'(pos_q);
  assign near_head  = CNT_W'(pos_q) <= tail_steps;
  assign walk_steps = near_head ? ADDR_W'(pos_q) : ADDR_W'(tail_steps);

  iqe_ram #(.WIDTH(DATA_W), .ADDR_W(ADDR_W)) u_slot_ram (
    .clk_i, .we_i(slot_we), .waddr_i(slot_waddr), .wdata_i(slot_wdata),
    .raddr_i(rd_addr), .rdata_o(slot_rd)
  );

  iqe_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(rd_addr), .rdata_o(next_rd)
  );

  iqe_ram #(.WIDTH(ADDR_W), .ADDR_W(ADDR_W)) u_prev_ram (
    .clk_i, .we_i(prev_we), .waddr_i(prev_waddr), .wdata_i(prev_wdata),
    .raddr_i(rd_addr), .rdata_o(prev_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (kind_q)
          KIND_POLL, KIND_PEEK: begin
            state_d = (count_q == '0) ? S_EMIT : S_ACCESS;
          end
          KIND_GET, KIND_SET, KIND_DELETE: begin
            if (CNT_W'(pos_q) >= count_q) state_d = S_EMIT;
            else if (walk_steps == '0)    state_d = S_ACCESS;
            else                          state_d = S_WALK;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_WALK: begin
        if (steps_q == ADDR_W'(1)) state_d = S_ACCESS;
      end
      S_ACCESS: begin
        state_d = (kind_q == KIND_SET) ? S_EMIT : S_FINISH;
      end
      S_FINISH: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    in_ready_o   = (state_q == S_IDLE);
    out_load     = 1'b0;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    free_d       = free_q;
    dir_head_d   = dir_head_q;
    steps_d      = steps_q;
    target_d     = target_q;
    res_hit_d    = res_hit_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    rd_addr      = target_q;
    slot_we      = 1'b0;
    slot_waddr   = target_q;
    slot_wdata   = value_q;
    next_we      = 1'b0;
    next_waddr   = tail_q;
    next_wdata   = free_slot;
    prev_we      = 1'b0;
    prev_waddr   = free_slot;
    prev_wdata   = tail_q;

    case (state_q)
      S_DISPATCH: begin
        res_hit_d    = 1'b0;
        res_status_d = ST_OK;
        res_data_d   = '0;
        case (kind_q)
          KIND_OFFER: begin
            if (count_q == CNT_W'(DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              slot_we           = 1'b1;
              slot_waddr        = free_slot;
              free_d[free_slot] = 1'b0;
              if (count_q == '0) begin
                head_d = free_slot;
              end else begin
                next_we = 1'b1;
                prev_we = 1'b1;
              end
              tail_d    = free_slot;
              count_d   = count_q + CNT_W'(1);
              res_hit_d = 1'b1;
            end
          end
          KIND_POLL, KIND_PEEK: begin
            if (count_q == '0) res_status_d = ST_MISS;
            else               target_d = head_q;
          end
          KIND_GET, KIND_SET, KIND_DELETE: begin
            if (CNT_W'(pos_q) >= count_q) begin
              res_status_d = ST_MISS;
            end else begin
              dir_head_d = near_head;
              steps_d    = walk_steps;
              target_d   = near_head ? head_q : tail_q;
              // First hop is read from whichever end is nearer.
              rd_addr    = near_head ? head_q : tail_q;
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (steps_q == ADDR_W'(1)) begin
          target_d = link_rd;
        end else begin
          rd_addr = link_rd;
          steps_d = steps_q - ADDR_W'(1);
        end
      end
      S_ACCESS: begin
        rd_addr = target_q;
        if (kind_q == KIND_SET) begin
          slot_we      = 1'b1;
          res_hit_d    = 1'b1;
          res_status_d = ST_OK;
          res_data_d   = '0;
        end
      end
      S_FINISH: begin
        res_hit_d    = 1'b1;
        res_status_d = ST_OK;
        res_data_d   = slot_rd;
        if (kind_q == KIND_POLL || kind_q == KIND_DELETE) begin
          if (count_q == CNT_W'(1)) begin
            head_d = '0;
            tail_d = '0;
          end else if (target_q == head_q) begin
            head_d = next_rd;
          end else if (target_q == tail_q) begin
            tail_d = prev_rd;
          end else begin
            // Middle slot: splice its neighbors together.
            next_we    = 1'b1;
            next_waddr = prev_rd;
            next_wdata = next_rd;
            prev_we    = 1'b1;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
          end
          free_d[target_q] = 1'b1;
          count_d          = count_q - CNT_W'(1);
        end
      end
      S_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      free_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      pos_q   <= position_i;
      value_q <= value_i;
    end
    dir_head_q   <= dir_head_d;
    steps_q      <= steps_d;
    target_q     <= target_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_count_q  <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign status_o    = out_status_q;
  assign data_out_o  = out_data_q;
  assign count_o     = out_count_q;

  // Every slot is either linked or free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_q) + int'(count_q) == DEPTH)
    else $error("free map and element count disagree");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> head_q == '0 && tail_q == '0)
    else $error("empty queue with nonzero head or tail");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> steps_q != '0)
    else $error("link walk entered with no hops left");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |-> !free_q[target_q])
    else $error("accessed slot is marked free");

endmodule

[sv/iqe_ram.sv]
// Simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module iqe_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  localparam int unsigned Words = 2 ** ADDR_W;

  logic [WIDTH-1:0] mem [Words];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
